// ===== design/kns_pkg.sv =====
// shared types and constants for the k-nearest sorted queue
package kns_pkg;

   // widths fixed by the item fields
   localparam int unsigned CNT_W    = 5;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned WORD_W   = 32;

   // slots built into the list
   localparam int unsigned MAX_NEIGHBOURS = 16;

   // readout emits at most this many slots
   localparam logic [CNT_W-1:0] READ_LIMIT = 5'd16;

   // k after reset
   localparam logic [CNT_W-1:0] K_RESET = 5'd16;

   // distance that stands for an empty slot
   localparam logic [WORD_W-1:0] DIST_INF = '1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READOUT = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_READOUT  = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic             load_insert;
      logic             load_clear;
      logic             load_read;
      logic             read_last;
      logic [CNT_W-1:0] read_addr;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [CNT_W-1:0] read_len;
   } stat_type;

endpackage

// ===== design/kns_if.sv =====
// request and response channel interfaces

// request channel: one candidate, clear or readout order per beat
interface kns_req_if;
   logic                                valid;
   logic                                ready;
   logic [kns_pkg::MODE_W-1:0]          mode;
   logic [kns_pkg::WORD_W-1:0]          point_id;
   logic [kns_pkg::WORD_W-1:0]          distance;

   modport source (output valid, output mode, output point_id, output distance,
                   input ready);
   modport sink   (input valid, input mode, input point_id, input distance,
                   output ready);
endinterface

// response channel: one result per beat
interface kns_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [kns_pkg::STATUS_W-1:0]        status;
   logic [kns_pkg::SLOT_W-1:0]          slot;
   logic [kns_pkg::WORD_W-1:0]          out_index;
   logic [kns_pkg::WORD_W-1:0]          out_distance;
   logic                                entry_valid;
   logic [kns_pkg::CNT_W-1:0]           fill_count;
   logic                                last;

   modport source (output valid, output status, output slot, output out_index,
                   output out_distance, output entry_valid, output fill_count,
                   output last, input ready);
   modport sink   (input valid, input status, input slot, input out_index,
                   input out_distance, input entry_valid, input fill_count,
                   input last, output ready);
endinterface

// ===== design/kns_ctrl.sv =====
// controller: request acceptance, readout sequencing and response valid
module kns_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [kns_pkg::MODE_W-1:0]  req_mode,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   input  kns_pkg::stat_type           stat,
   output kns_pkg::cmd_type            cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_READ = 1'b1;

   logic [0:0]                 state_ff, state_in;
   logic [kns_pkg::CNT_W-1:0]  rd_ff, rd_in;
   logic                       valid_ff, valid_in;
   logic                       out_free;
   logic                       accept;
   logic                       rd_last;

   // output register can take a beat this cycle
   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rd_last   = (kns_pkg::CNT_W'(rd_ff + 1'b1) == stat.read_len);
   assign rsp_valid = valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      rd_in    = rd_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      cmd.read_addr = rd_ff;
      cmd.read_last = rd_last;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  kns_pkg::MODE_INSERT: begin
                     cmd.load_insert = 1'b1;
                     valid_in        = 1'b1;
                  end
                  kns_pkg::MODE_CLEAR: begin
                     cmd.load_clear = 1'b1;
                     valid_in       = 1'b1;
                  end
                  kns_pkg::MODE_READOUT: begin
                     state_in = ST_READ;
                     rd_in    = '0;
                  end
                  default: begin
                     // unused mode is dropped without a result
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               cmd.load_read = 1'b1;
               valid_in      = 1'b1;
               rd_in         = kns_pkg::CNT_W'(rd_ff + 1'b1);
               if (rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== design/kns_dp.sv =====
// datapath: sorted slot array, fill count, k register and response payload
module kns_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [kns_pkg::CNT_W-1:0]     csr_write_data,
   input  logic [kns_pkg::WORD_W-1:0]    req_point_id,
   input  logic [kns_pkg::WORD_W-1:0]    req_distance,
   input  kns_pkg::cmd_type              cmd,
   output kns_pkg::stat_type             stat,
   output logic [kns_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kns_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [kns_pkg::WORD_W-1:0]    rsp_out_index,
   output logic [kns_pkg::WORD_W-1:0]    rsp_out_distance,
   output logic                          rsp_entry_valid,
   output logic [kns_pkg::CNT_W-1:0]     rsp_fill_count,
   output logic                          rsp_last
);

   localparam int unsigned MAX_NEIGHBOURS = kns_pkg::MAX_NEIGHBOURS;
   localparam int unsigned CW = kns_pkg::CNT_W;
   localparam int unsigned WW = kns_pkg::WORD_W;

   // clamp a k value to 1..capacity
   function automatic logic [CW-1:0] clamp_k(input logic [CW-1:0] kv);
      logic [CW-1:0] r;
      r = kv;
      if (kv == '0) begin
         r = CW'(1);
      end else if (32'(kv) > MAX_NEIGHBOURS) begin
         r = CW'(MAX_NEIGHBOURS);
      end
      return r;
   endfunction

   logic [WW-1:0]                 dist_ff [MAX_NEIGHBOURS];
   logic [WW-1:0]                 dist_in [MAX_NEIGHBOURS];
   logic [WW-1:0]                 idx_ff  [MAX_NEIGHBOURS];
   logic [WW-1:0]                 idx_in  [MAX_NEIGHBOURS];
   logic [CW-1:0]                 k_ff, k_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 k_eff;
   logic [CW-1:0]                 k_new;
   logic [MAX_NEIGHBOURS-1:0]     le;
   logic [CW-1:0]                 pos;
   logic                          full;
   logic                          reject;
   logic                          write_slots;
   logic [WW-1:0]                 sel_dist;
   logic [WW-1:0]                 sel_idx;
   logic                          rd_valid;

   logic [kns_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [kns_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [WW-1:0]                 oidx_ff, oidx_in;
   logic [WW-1:0]                 odist_ff, odist_in;
   logic                          ev_ff, ev_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic                          last_ff, last_in;

   assign k_eff = clamp_k(k_ff);
   assign k_new = clamp_k(csr_write_data);
   assign stat.read_len = (k_eff > kns_pkg::READ_LIMIT) ? kns_pkg::READ_LIMIT : k_eff;

   // per-slot compare against the candidate, masked to held entries
   always_comb begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         le[i] = (32'(cnt_ff) > i) && (dist_ff[i] <= req_distance);
      end
   end

   // insertion point is the first slot whose entry is not at or below the candidate
   always_comb begin
      pos = cnt_ff;
      for (int i = MAX_NEIGHBOURS - 1; i >= 0; i--) begin
         if (!le[i]) begin
            pos = CW'(i);
         end
      end
   end

   // a full list rejects a candidate that lands past the end
   assign full        = (cnt_ff >= k_eff);
   assign reject      = full && (pos == cnt_ff);
   assign write_slots = cmd.load_insert && !reject;

   // shift network: slots behind the insertion point move down one
   generate
      for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_slot
         if (g == 0) begin : g_head
            always_comb begin
               dist_in[g] = dist_ff[g];
               idx_in[g]  = idx_ff[g];
               if (pos == '0) begin
                  dist_in[g] = req_distance;
                  idx_in[g]  = req_point_id;
               end
            end
         end else begin : g_body
            always_comb begin
               dist_in[g] = dist_ff[g];
               idx_in[g]  = idx_ff[g];
               if (32'(pos) == g) begin
                  dist_in[g] = req_distance;
                  idx_in[g]  = req_point_id;
               end else if (32'(pos) < g) begin
                  dist_in[g] = dist_ff[g-1];
                  idx_in[g]  = idx_ff[g-1];
               end
            end
         end
         always_ff @(posedge clock) begin
            if (write_slots) begin
               dist_ff[g] <= dist_in[g];
               idx_ff[g]  <= idx_in[g];
            end
         end
      end
   endgenerate

   // readout slot select
   always_comb begin
      sel_dist = '0;
      sel_idx  = '0;
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         if (32'(cmd.read_addr) == i) begin
            sel_dist = dist_ff[i];
            sel_idx  = idx_ff[i];
         end
      end
   end
   assign rd_valid = (cmd.read_addr < cnt_ff);

   // fill count and k register
   always_comb begin
      k_in   = k_ff;
      cnt_in = cnt_ff;
      if (csr_write_enable) begin
         k_in = csr_write_data;
         if (cnt_ff > k_new) begin
            cnt_in = k_new;
         end
      end else if (cmd.load_clear) begin
         cnt_in = '0;
      end else if (write_slots && !full) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= kns_pkg::K_RESET;
         cnt_ff <= '0;
      end else begin
         k_ff   <= k_in;
         cnt_ff <= cnt_in;
      end
   end

   // response payload for the next beat
   always_comb begin
      status_in = status_ff;
      slot_in   = slot_ff;
      oidx_in   = oidx_ff;
      odist_in  = odist_ff;
      ev_in     = ev_ff;
      fill_in   = fill_ff;
      last_in   = last_ff;
      if (cmd.load_insert) begin
         status_in = reject ? kns_pkg::STATUS_REJECTED : kns_pkg::STATUS_INSERTED;
         slot_in   = reject ? '0 : pos[kns_pkg::SLOT_W-1:0];
         oidx_in   = '0;
         odist_in  = '0;
         ev_in     = 1'b0;
         fill_in   = cnt_in;
         last_in   = 1'b1;
      end else if (cmd.load_clear) begin
         status_in = kns_pkg::STATUS_CLEARED;
         slot_in   = '0;
         oidx_in   = '0;
         odist_in  = '0;
         ev_in     = 1'b0;
         fill_in   = '0;
         last_in   = 1'b1;
      end else if (cmd.load_read) begin
         status_in = kns_pkg::STATUS_READOUT;
         slot_in   = cmd.read_addr[kns_pkg::SLOT_W-1:0];
         oidx_in   = rd_valid ? sel_idx : '0;
         odist_in  = rd_valid ? sel_dist : kns_pkg::DIST_INF;
         ev_in     = rd_valid;
         fill_in   = cnt_ff;
         last_in   = cmd.read_last;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      oidx_ff   <= oidx_in;
      odist_ff  <= odist_in;
      ev_ff     <= ev_in;
      fill_ff   <= fill_in;
      last_ff   <= last_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_out_index    = oidx_ff;
   assign rsp_out_distance = odist_ff;
   assign rsp_entry_valid  = ev_ff;
   assign rsp_fill_count   = fill_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== design/k_nearest_sorted_queue.sv =====
// top level of the k-nearest sorted queue
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    mode, point_id, distance
//   rsp      out  valid/ready    status, slot, out_index, out_distance,
//                                entry_valid, fill_count, last
//   csr      in   write enable   k_in_use (5 bits)
//
// insert and clear load their result into the output register the next cycle, and a
// new request is taken while the previous beat is taken.
// readout emits n = min(k, 16) slots, one slot per cycle while the output register
// is free, through the slot select mux into the output register.
// synchronous reset empties the list and sets k to 16 at once.
// rsp_ready low while a beat is valid holds the output register and blocks new requests.
module k_nearest_sorted_queue (
   input  logic                       clock,
   input  logic                       reset,
   kns_req_if.sink                    req,
   kns_rsp_if.source                  rsp,
   input  logic                       csr_write_enable,
   input  logic [kns_pkg::CNT_W-1:0]  csr_write_data
);

   kns_pkg::cmd_type   cmd;
   kns_pkg::stat_type  stat;

   // sequencing
   kns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot array and payload
   kns_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_point_id     (req.point_id),
      .req_distance     (req.distance),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp.status),
      .rsp_slot         (rsp.slot),
      .rsp_out_index    (rsp.out_index),
      .rsp_out_distance (rsp.out_distance),
      .rsp_entry_valid  (rsp.entry_valid),
      .rsp_fill_count   (rsp.fill_count),
      .rsp_last         (rsp.last)
   );

endmodule
